// File: rtl/tcw_pkg.sv
// Shared constants and codes of the text console writer.
// Depends on nothing; the top level takes names from here.
package tcw_pkg;

   // screen geometry
   localparam int ROWS     = 25;
   localparam int COLS     = 80;
   localparam int TAB_STEP = 4;
   localparam int CELLS    = ROWS * COLS;

   // field widths
   localparam int OP_W     = 2;
   localparam int CHAR_W   = 8;
   localparam int ATTR_W   = 8;
   localparam int RROW_W   = 5;
   localparam int COL_W    = 7;
   localparam int POS_W    = 11;

   // internal widths
   localparam int PROW_W   = $clog2(ROWS);
   localparam int ADDR_W   = $clog2(CELLS);
   localparam int CELL_W   = CHAR_W + ATTR_W;

   // operation codes
   localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
   localparam logic [OP_W-1:0] OP_READ  = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

   // control characters
   localparam logic [CHAR_W-1:0] CH_NUL = 8'd0;
   localparam logic [CHAR_W-1:0] CH_TAB = 8'd9;
   localparam logic [CHAR_W-1:0] CH_LF  = 8'd10;
   localparam logic [CHAR_W-1:0] CH_CR  = 8'd13;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_RDWAIT = 3'b010,
      ST_SWEEP  = 3'b100
   } state_type;

endpackage

// File: rtl/text_console_writer.sv
// Top level of the text console writer: cursor, row ring, response register.
// Depends on tcw_pkg and tcw_ram.

// A read passes through the read-wait state, since the cell RAM registers
// its read word. Screen rows sit in a ring with a top-row pointer and one
// blank flag per row, so a scroll and a clear need no pass over the RAM.
// The first character printed into a blank row sweeps that row through the
// single RAM write port, column by column, writing zeros and the new
// character. Reset needs no clearing pass: all rows start blank. A
// new word is taken only when the response register is empty or its word
// leaves in the same cycle, and no read or sweep is still in progress.
module text_console_writer (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [tcw_pkg::OP_W-1:0]    req_op,
   input  logic [tcw_pkg::CHAR_W-1:0]  req_ch,
   input  logic [tcw_pkg::ATTR_W-1:0]  req_color,
   input  logic [tcw_pkg::RROW_W-1:0]  req_read_row,
   input  logic [tcw_pkg::COL_W-1:0]   req_read_col,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [tcw_pkg::POS_W-1:0]   rsp_cursor_position,
   output logic [tcw_pkg::CHAR_W-1:0]  rsp_cell_char,
   output logic [tcw_pkg::ATTR_W-1:0]  rsp_cell_attr
);

   localparam int PROW_W = tcw_pkg::PROW_W;
   localparam int COL_W  = tcw_pkg::COL_W;
   localparam int ADDR_W = tcw_pkg::ADDR_W;
   localparam int POS_W  = tcw_pkg::POS_W;

   tcw_pkg::state_type state_ff, state_in;

   logic [PROW_W-1:0]        cur_row_ff, cur_row_in;
   logic [COL_W-1:0]         cur_col_ff, cur_col_in;
   logic [PROW_W-1:0]        top_ff, top_in;
   logic [tcw_pkg::ROWS-1:0] blank_ff, blank_in;
   logic [COL_W-1:0]         sweep_ff, sweep_in;
   logic [tcw_pkg::CHAR_W-1:0] item_ch_ff, item_ch_in;
   logic [tcw_pkg::ATTR_W-1:0] item_color_ff, item_color_in;
   logic                     rd_hit_ff, rd_hit_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [POS_W-1:0]         rsp_pos_ff, rsp_pos_in;
   logic [tcw_pkg::CHAR_W-1:0] rsp_char_ff, rsp_char_in;
   logic [tcw_pkg::ATTR_W-1:0] rsp_attr_ff, rsp_attr_in;

   logic                     ram_we;
   logic [ADDR_W-1:0]        ram_waddr, ram_raddr;
   logic [tcw_pkg::CELL_W-1:0] ram_wdata, ram_rdata;

   logic                     accept;
   logic [tcw_pkg::CHAR_W-1:0] adv_ch;
   logic [COL_W:0]           col_adv;
   logic                     col_wrap;
   logic [PROW_W-1:0]        row_next;
   logic [COL_W-1:0]         col_next;
   logic                     scroll;
   logic [PROW_W-1:0]        cur_prow, rd_prow;
   logic                     rd_in_range;

   // map a screen row onto its place in the ring
   function automatic logic [PROW_W-1:0] ring_row(input logic [PROW_W-1:0] lrow,
                                                   input logic [PROW_W-1:0] top);
      logic [PROW_W:0] sum;
      sum = {1'b0, lrow} + {1'b0, top};
      if (sum >= (PROW_W+1)'(tcw_pkg::ROWS)) begin
         sum = sum - (PROW_W+1)'(tcw_pkg::ROWS);
      end
      return sum[PROW_W-1:0];
   endfunction

   function automatic logic [ADDR_W-1:0] cell_addr(input logic [PROW_W-1:0] prow,
                                                    input logic [COL_W-1:0]  col);
      return ADDR_W'(ADDR_W'(prow) * ADDR_W'(tcw_pkg::COLS)) + ADDR_W'(col);
   endfunction

   function automatic logic [POS_W-1:0] lin_pos(input logic [PROW_W-1:0] row,
                                                 input logic [COL_W-1:0]  col);
      return POS_W'(POS_W'(row) * POS_W'(tcw_pkg::COLS)) + POS_W'(col);
   endfunction

   assign accept    = req_valid && !req_stall;
   assign req_stall = !((state_ff == tcw_pkg::ST_IDLE) && (!rsp_valid_ff || !rsp_stall));

   assign cur_prow    = ring_row(cur_row_ff, top_ff);
   assign rd_prow     = ring_row(PROW_W'(req_read_row), top_ff);
   assign rd_in_range = (int'(req_read_row) < tcw_pkg::ROWS) &&
                        (int'(req_read_col) < tcw_pkg::COLS);

   // advance the cursor for the character at hand
   assign adv_ch = (state_ff == tcw_pkg::ST_SWEEP) ? item_ch_ff : req_ch;

   always_comb begin
      if (adv_ch == tcw_pkg::CH_CR) begin
         col_adv = '0;
      end else if (adv_ch == tcw_pkg::CH_LF) begin
         col_adv = (COL_W+1)'(tcw_pkg::COLS);
      end else if (adv_ch == tcw_pkg::CH_TAB) begin
         col_adv = {1'b0, cur_col_ff} + (COL_W+1)'(tcw_pkg::TAB_STEP);
      end else begin
         col_adv = {1'b0, cur_col_ff} + (COL_W+1)'(1);
      end
      col_wrap = (col_adv >= (COL_W+1)'(tcw_pkg::COLS));
      col_next = col_wrap ? COL_W'(col_adv - (COL_W+1)'(tcw_pkg::COLS))
                          : col_adv[COL_W-1:0];
      scroll   = col_wrap && (cur_row_ff == PROW_W'(tcw_pkg::ROWS - 1));
      row_next = (col_wrap && !scroll) ? cur_row_ff + PROW_W'(1) : cur_row_ff;
   end

   // sequencer: decode the word, drive the RAM, load the response
   always_comb begin
      state_in      = state_ff;
      cur_row_in    = cur_row_ff;
      cur_col_in    = cur_col_ff;
      top_in        = top_ff;
      blank_in      = blank_ff;
      sweep_in      = sweep_ff;
      item_ch_in    = item_ch_ff;
      item_color_in = item_color_ff;
      rd_hit_in     = rd_hit_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_pos_in    = rsp_pos_ff;
      rsp_char_in   = rsp_char_ff;
      rsp_attr_in   = rsp_attr_ff;
      ram_we        = 1'b0;
      ram_waddr     = cell_addr(cur_prow, cur_col_ff);
      ram_wdata     = {req_ch, req_color};
      ram_raddr     = cell_addr(rd_prow, req_read_col);

      case (state_ff)
         tcw_pkg::ST_IDLE: begin
            if (accept) begin
               rsp_pos_in  = lin_pos(cur_row_ff, cur_col_ff);
               rsp_char_in = '0;
               rsp_attr_in = '0;
               if (req_op == tcw_pkg::OP_READ) begin
                  rd_hit_in = rd_in_range && !blank_ff[rd_prow];
                  state_in  = tcw_pkg::ST_RDWAIT;
               end else if (req_op == tcw_pkg::OP_CLEAR) begin
                  blank_in     = '1;
                  rsp_valid_in = 1'b1;
               end else if (req_op == tcw_pkg::OP_PUT && req_ch != tcw_pkg::CH_NUL) begin
                  if (req_ch != tcw_pkg::CH_CR && req_ch != tcw_pkg::CH_LF &&
                      req_ch != tcw_pkg::CH_TAB && blank_ff[cur_prow]) begin
                     // first print into a blank row: sweep it
                     item_ch_in    = req_ch;
                     item_color_in = req_color;
                     sweep_in      = '0;
                     state_in      = tcw_pkg::ST_SWEEP;
                  end else begin
                     ram_we = (req_ch != tcw_pkg::CH_CR && req_ch != tcw_pkg::CH_LF &&
                               req_ch != tcw_pkg::CH_TAB);
                     cur_row_in = row_next;
                     cur_col_in = col_next;
                     if (scroll) begin
                        top_in = (top_ff == PROW_W'(tcw_pkg::ROWS - 1)) ? '0
                                                                         : top_ff + PROW_W'(1);
                        blank_in[top_ff] = 1'b1;
                     end
                     rsp_pos_in   = lin_pos(row_next, col_next);
                     rsp_valid_in = 1'b1;
                  end
               end else begin
                  rsp_valid_in = 1'b1;
               end
            end
         end
         tcw_pkg::ST_RDWAIT: begin
            rsp_char_in  = rd_hit_ff ? ram_rdata[tcw_pkg::CELL_W-1:tcw_pkg::ATTR_W] : '0;
            rsp_attr_in  = rd_hit_ff ? ram_rdata[tcw_pkg::ATTR_W-1:0] : '0;
            rsp_valid_in = 1'b1;
            state_in     = tcw_pkg::ST_IDLE;
         end
         tcw_pkg::ST_SWEEP: begin
            // zero the row, drop the character in at the cursor column
            ram_we    = 1'b1;
            ram_waddr = cell_addr(cur_prow, sweep_ff);
            ram_wdata = (sweep_ff == cur_col_ff) ? {item_ch_ff, item_color_ff} : '0;
            sweep_in  = sweep_ff + COL_W'(1);
            if (sweep_ff == COL_W'(tcw_pkg::COLS - 1)) begin
               blank_in[cur_prow] = 1'b0;
               cur_row_in = row_next;
               cur_col_in = col_next;
               if (scroll) begin
                  top_in = (top_ff == PROW_W'(tcw_pkg::ROWS - 1)) ? '0
                                                                   : top_ff + PROW_W'(1);
                  blank_in[top_ff] = 1'b1;
               end
               rsp_pos_in   = lin_pos(row_next, col_next);
               rsp_char_in  = '0;
               rsp_attr_in  = '0;
               rsp_valid_in = 1'b1;
               state_in     = tcw_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tcw_pkg::ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tcw_pkg::ST_IDLE;
         cur_row_ff   <= '0;
         cur_col_ff   <= '0;
         top_ff       <= '0;
         blank_ff     <= '1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_row_ff   <= cur_row_in;
         cur_col_ff   <= cur_col_in;
         top_ff       <= top_in;
         blank_ff     <= blank_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      sweep_ff      <= sweep_in;
      item_ch_ff    <= item_ch_in;
      item_color_ff <= item_color_in;
      rd_hit_ff     <= rd_hit_in;
      rsp_pos_ff    <= rsp_pos_in;
      rsp_char_ff   <= rsp_char_in;
      rsp_attr_ff   <= rsp_attr_in;
   end

   tcw_ram #(
      .WIDTH (tcw_pkg::CELL_W),
      .DEPTH (tcw_pkg::CELLS)
   ) u_cells (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_cursor_position = rsp_pos_ff;
   assign rsp_cell_char       = rsp_char_ff;
   assign rsp_cell_attr       = rsp_attr_ff;

   // a read or sweep runs only with the response register empty
   a_busy_rsp_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff != tcw_pkg::ST_IDLE) |-> !rsp_valid_ff)
      else $error("response pending while a read or sweep runs");

   // the sweep only ever starts on a blank row and stays inside it
   a_sweep_blank: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tcw_pkg::ST_SWEEP) |-> (blank_ff[cur_prow] &&
                                           sweep_ff < COL_W'(tcw_pkg::COLS)))
      else $error("sweep on a row that is not blank");

   // a read's response follows its read-wait state
   a_read_latency: assert property (@(posedge clock) disable iff (reset)
      (accept && req_op == tcw_pkg::OP_READ) |=> ##1 rsp_valid_ff)
      else $error("read result missing");

   // the cursor stays on the screen
   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (int'(rsp_pos_ff) < tcw_pkg::CELLS))
      else $error("cursor off screen");

endmodule

// File: rtl/tcw_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
module tcw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write, then register the read word
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
